[rtl/core/drsp_pkg.sv]
// Shared types, widths and codes of the distance run speed profiler.
`timescale 1ns / 1ps

package drsp_pkg;

	// Widths of the sample fields and of the distance sum.
	localparam int COUNT_BITS = 24;
	localparam int IN_W       = 24;
	localparam int SUM_W      = IN_W + 1;
	localparam int SAT_W      = (COUNT_BITS > SUM_W) ? COUNT_BITS : SUM_W;

	// Configuration registers.
	localparam int CFG_W  = 16;
	localparam int APB_DW = 32;
	localparam int ADDR_W = 4;

	// Shared multiplier and the fraction arithmetic.
	localparam int MUL_A_W = COUNT_BITS;
	localparam int MUL_B_W = CFG_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int DIV_W   = 32;
	localparam int ROOT_W  = 16;
	localparam int CNT_W   = 5;

	localparam int SCALE_MM  = 10000;
	localparam int RAMP_SPAN = 300;
	localparam int LAMP_MAX  = 255;

	// Result field widths.
	localparam int PULSE_W = 11;
	localparam int LED_W   = 8;
	localparam int COLOR_W = 3 * LED_W;
	localparam int PHASE_W = 3;

	// Run phases.
	localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_ARMED  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_ACCEL  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_CRUISE = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DECEL  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_ESTOP  = 3'd5;

	// Pulse widths in microseconds.
	localparam logic [PULSE_W-1:0] PULSE_STOP    = 11'd1100;
	localparam logic [PULSE_W-1:0] PULSE_NEUTRAL = 11'd1500;
	localparam logic [PULSE_W-1:0] PULSE_SLOW    = 11'd1600;
	localparam logic [PULSE_W-1:0] PULSE_CRUISE  = 11'd1900;

	// Lamp colors, red in the top byte.
	localparam logic [COLOR_W-1:0] COLOR_RED    = 24'hFF0000;
	localparam logic [COLOR_W-1:0] COLOR_GREEN  = 24'h00FF00;
	localparam logic [COLOR_W-1:0] COLOR_YELLOW = 24'hFFFF00;
	localparam logic [COLOR_W-1:0] COLOR_BLUE   = 24'h0000FF;

	typedef struct packed {
		logic [CFG_W-1:0] ticks_per_meter_tenths;
		logic [CFG_W-1:0] run_distance_mm;
		logic [CFG_W-1:0] accel_distance_mm;
		logic [CFG_W-1:0] decel_distance_mm;
	} drsp_cfg_t;

endpackage

[rtl/core/drsp_in_if.sv]
// Sample channel: encoder counts and buttons with a valid/ready handshake.
`timescale 1ns / 1ps

interface drsp_in_if;
	import drsp_pkg::*;

	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] left_count;
	logic signed [IN_W-1:0] right_count;
	logic                   go_button;
	logic                   stop_button;

	modport source (
		output valid, left_count, right_count, go_button, stop_button,
		input  ready
	);

	modport sink (
		input  valid, left_count, right_count, go_button, stop_button,
		output ready
	);
endinterface

[rtl/core/drsp_out_if.sv]
// Result channel: drive command, lamp color and phase with a valid/ready handshake.
`timescale 1ns / 1ps

interface drsp_out_if;
	import drsp_pkg::*;

	logic               valid;
	logic               ready;
	logic [PULSE_W-1:0] esc_pulse_us;
	logic [LED_W-1:0]   led_red;
	logic [LED_W-1:0]   led_green;
	logic [LED_W-1:0]   led_blue;
	logic               boost_enable;
	logic               clear_counts;
	logic [PHASE_W-1:0] run_phase;

	modport source (
		output valid, esc_pulse_us, led_red, led_green, led_blue, boost_enable,
		       clear_counts, run_phase,
		input  ready
	);

	modport sink (
		input  valid, esc_pulse_us, led_red, led_green, led_blue, boost_enable,
		       clear_counts, run_phase,
		output ready
	);
endinterface

[rtl/core/drsp_cfg.sv]
// APB register file holding the four run configuration registers.
`timescale 1ns / 1ps

module drsp_cfg import drsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output drsp_cfg_t         cfg
);

	localparam logic [1:0] REG_TICKS = 2'd0;
	localparam logic [1:0] REG_RUN   = 2'd1;
	localparam logic [1:0] REG_ACCEL = 2'd2;
	localparam logic [1:0] REG_DECEL = 2'd3;

	drsp_cfg_t  cfg_q;
	logic       wr_en;
	logic [1:0] reg_sel;
	logic [CFG_W-1:0] rd_val;

	assign pready  = 1'b1;
	assign reg_sel = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_meter_tenths <= 16'd1461;
			cfg_q.run_distance_mm        <= 16'd8500;
			cfg_q.accel_distance_mm      <= 16'd500;
			cfg_q.decel_distance_mm      <= 16'd1500;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_TICKS: cfg_q.ticks_per_meter_tenths <= pwdata[CFG_W-1:0];
				REG_RUN:   cfg_q.run_distance_mm        <= pwdata[CFG_W-1:0];
				REG_ACCEL: cfg_q.accel_distance_mm      <= pwdata[CFG_W-1:0];
				REG_DECEL: cfg_q.decel_distance_mm      <= pwdata[CFG_W-1:0];
				default:   cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_TICKS: rd_val = cfg_q.ticks_per_meter_tenths;
			REG_RUN:   rd_val = cfg_q.run_distance_mm;
			REG_ACCEL: rd_val = cfg_q.accel_distance_mm;
			REG_DECEL: rd_val = cfg_q.decel_distance_mm;
			default:   rd_val = '0;
		endcase
	end

	assign prdata = {{(APB_DW - CFG_W){1'b0}}, rd_val};

endmodule

[rtl/core/distance_run_speed_profiler_core.sv]
// Distance run speed profiler: turns one encoder and button sample into one drive
// command, lamp color and phase. Each accepted sample gives exactly one result.
// A sample that stops, arms, leaves the stop or finds the block idle goes straight
// to the finishing state. A sample in a running phase, or the release of go, first
// forms the four distance products (the distance sum times 10000 and the three
// configuration products) one after another in a single 24 by 16 bit multiplier.
// While the run is still on the acceleration ramp, the progress fraction is found
// by a 32 step restoring divide and then its square root by a 16 step digit
// recurrence. Both use the same subtractor, and two more passes through the
// multiplier scale the root for the pulse and the lamp. The sample port is ready
// only while the sequencer is idle. A finished result waits in the output
// register, so the next sample may be accepted before the previous result has
// been taken. Configuration must be written over the APB port only while no
// sample is in flight; the block itself does not enforce this. Registers lie at
// byte offsets 0, 4, 8 and 12.
`timescale 1ns / 1ps

module distance_run_speed_profiler_core import drsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	drsp_in_if.sink           sample,
	drsp_out_if.source        result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// Sequencer states.
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_S10    = 4'd1;
	localparam logic [3:0] ST_A      = 4'd2;
	localparam logic [3:0] ST_THR    = 4'd3;
	localparam logic [3:0] ST_END    = 4'd4;
	localparam logic [3:0] ST_DECIDE = 4'd5;
	localparam logic [3:0] ST_DIV    = 4'd6;
	localparam logic [3:0] ST_ROOT   = 4'd7;
	localparam logic [3:0] ST_P300   = 4'd8;
	localparam logic [3:0] ST_P255   = 4'd9;
	localparam logic [3:0] ST_FIN    = 4'd10;

	localparam logic [SAT_W-1:0] S_LIMIT =
		SAT_W'((64'd1 << COUNT_BITS) - 64'd1);
	localparam logic [DIV_W-1:0] ROOT_BIT_INIT = DIV_W'(64'd1 << (DIV_W - 2));
	localparam int RND_W = 26;

	drsp_cfg_t cfg;

	// Control and held run state.
	logic [3:0]         state_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PULSE_W-1:0] pulse_q;
	logic [COLOR_W-1:0] color_q;
	logic               boost_q;
	logic               out_valid_q;

	// Datapath registers.
	logic [COUNT_BITS-1:0] s_q;
	logic [PHASE_W-1:0]    from_q;
	logic                  clear_q;
	logic [PROD_W-1:0]     s10_q;
	logic [PROD_W-1:0]     a_q;
	logic [PROD_W-1:0]     prod_q;
	logic                  lt_a_q;
	logic                  lt_thr_q;
	logic [DIV_W-1:0]      wrk_q;
	logic [DIV_W-1:0]      quot_q;
	logic [DIV_W-1:0]      res_q;
	logic [DIV_W-1:0]      bit_q;
	logic [CNT_W-1:0]      cnt_q;

	// Output register.
	logic [PULSE_W-1:0] o_pulse_q;
	logic [COLOR_W-1:0] o_color_q;
	logic               o_boost_q;
	logic               o_clear_q;
	logic [PHASE_W-1:0] o_phase_q;

	logic                  take;
	logic                  load_out;
	logic [IN_W-1:0]       mag_l;
	logic [IN_W-1:0]       mag_r;
	logic [SAT_W-1:0]      sum_w;
	logic [COUNT_BITS-1:0] s_sat;
	logic                  arm_release;

	logic [CFG_W:0]        run_diff;
	logic                  diff_neg;
	logic                  lt_end;

	logic [MUL_A_W-1:0]    mul_a;
	logic [MUL_B_W-1:0]    mul_b;
	logic [PROD_W-1:0]     mul_p;

	logic [DIV_W:0]        sub_m;
	logic [DIV_W:0]        sub_s;
	logic [DIV_W+1:0]      sub_d;
	logic                  sub_ge;
	logic [DIV_W:0]        rem2;

	logic [ROOT_W-1:0]     root_p;
	logic [RND_W-1:0]      ramp_rnd;
	logic [LED_W-1:0]      lamp_lv;

	drsp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The sample is taken only while the sequencer is idle.
	assign sample.ready = (state_q == ST_IDLE);
	assign take         = sample.valid && sample.ready;
	assign load_out     = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	// Distance sum: magnitudes of both counts, saturated to the count width.
	assign mag_l = sample.left_count[IN_W-1]  ? (~sample.left_count + 1'b1)
	                                          : sample.left_count;
	assign mag_r = sample.right_count[IN_W-1] ? (~sample.right_count + 1'b1)
	                                          : sample.right_count;
	assign sum_w = SAT_W'(mag_l) + SAT_W'(mag_r);
	assign s_sat = (sum_w > S_LIMIT) ? COUNT_BITS'(S_LIMIT) : COUNT_BITS'(sum_w);

	// Releasing go from the armed phase judges the run at zero distance.
	assign arm_release = !sample.stop_button && !sample.go_button && (phase_q == PH_ARMED);

	// The cruise limit is negative when the slow zone is longer than the run.
	assign run_diff = {1'b0, cfg.run_distance_mm} - {1'b0, cfg.decel_distance_mm};
	assign diff_neg = run_diff[CFG_W];
	assign lt_end   = (s10_q < prod_q);

	// Shared multiplier: operands chosen by the sequencer state.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_S10: begin
				mul_a = s_q;
				mul_b = MUL_B_W'(SCALE_MM);
			end
			ST_A: begin
				mul_a = MUL_A_W'(cfg.accel_distance_mm);
				mul_b = cfg.ticks_per_meter_tenths;
			end
			ST_THR: begin
				mul_a = MUL_A_W'(run_diff[CFG_W-1:0]);
				mul_b = cfg.ticks_per_meter_tenths;
			end
			ST_END: begin
				mul_a = MUL_A_W'(cfg.run_distance_mm);
				mul_b = cfg.ticks_per_meter_tenths;
			end
			ST_P300: begin
				mul_a = MUL_A_W'(RAMP_SPAN);
				mul_b = root_p;
			end
			ST_P255: begin
				mul_a = MUL_A_W'(LAMP_MAX);
				mul_b = root_p;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

	// Shared subtractor: divide step against the ramp length, or root step
	// against the partial root plus the current bit.
	assign rem2 = {wrk_q, 1'b0};

	always_comb begin
		if (state_q == ST_DIV) begin
			sub_m = rem2;
			sub_s = {1'b0, a_q[DIV_W-1:0]};
		end else begin
			sub_m = {1'b0, wrk_q};
			sub_s = {1'b0, res_q} + {1'b0, bit_q};
		end
	end

	assign sub_d  = {1'b0, sub_m} - {1'b0, sub_s};
	assign sub_ge = !sub_d[DIV_W+1];

	// Progress root scaling for pulse (rounded) and lamp level (truncated).
	assign root_p   = res_q[ROOT_W-1:0];
	assign ramp_rnd = mul_p[RND_W-1:0] + RND_W'(32'd32768);
	assign lamp_lv  = mul_p[ROOT_W+LED_W-1:ROOT_W];

	// Sequencer and held run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_IDLE;
			pulse_q     <= PULSE_NEUTRAL;
			color_q     <= '0;
			boost_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one that leaves in the same cycle.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (sample.stop_button) begin
							phase_q <= PH_ESTOP;
							pulse_q <= PULSE_NEUTRAL;
							color_q <= COLOR_RED;
							boost_q <= 1'b0;
							state_q <= ST_FIN;
						end else begin
							case (phase_q) inside
								PH_IDLE, PH_ARMED: begin
									if (sample.go_button) begin
										phase_q <= PH_ARMED;
										boost_q <= 1'b1;
										pulse_q <= PULSE_NEUTRAL;
										color_q <= COLOR_GREEN;
										state_q <= ST_FIN;
									end else if (phase_q == PH_ARMED) begin
										state_q <= ST_S10;
									end else begin
										state_q <= ST_FIN;
									end
								end
								PH_ACCEL, PH_CRUISE, PH_DECEL: begin
									state_q <= ST_S10;
								end
								default: begin
									phase_q <= PH_IDLE;
									state_q <= ST_FIN;
								end
							endcase
						end
					end
				end
				ST_S10: state_q <= ST_A;
				ST_A:   state_q <= ST_THR;
				ST_THR: state_q <= ST_END;
				ST_END: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					if ((from_q == PH_ACCEL) && lt_a_q) begin
						phase_q <= PH_ACCEL;
						state_q <= ST_DIV;
					end else if (((from_q == PH_ACCEL) || (from_q == PH_CRUISE)) && lt_thr_q) begin
						phase_q <= PH_CRUISE;
						pulse_q <= PULSE_CRUISE;
						color_q <= COLOR_YELLOW;
						state_q <= ST_FIN;
					end else if (lt_end) begin
						phase_q <= PH_DECEL;
						pulse_q <= PULSE_SLOW;
						color_q <= COLOR_BLUE;
						state_q <= ST_FIN;
					end else begin
						phase_q <= PH_IDLE;
						pulse_q <= PULSE_STOP;
						color_q <= COLOR_RED;
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (cnt_q == '0) begin
						state_q <= ST_P300;
					end
				end
				ST_P300: begin
					pulse_q <= PULSE_SLOW + PULSE_W'(ramp_rnd[RND_W-1:ROOT_W]);
					state_q <= ST_P255;
				end
				ST_P255: begin
					color_q <= {lamp_lv, lamp_lv, {LED_W{1'b0}}};
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: captured sample, products, divide and root words.
	always_ff @(posedge clk) begin
		if (take) begin
			s_q     <= arm_release ? '0 : s_sat;
			from_q  <= (phase_q == PH_ARMED) ? PH_ACCEL : phase_q;
			clear_q <= !sample.stop_button &&
			           (sample.go_button ? ((phase_q == PH_IDLE) || (phase_q == PH_ARMED))
			                             : (phase_q == PH_ARMED));
		end
		unique case (state_q)
			ST_S10: s10_q <= mul_p;
			ST_A:   a_q   <= mul_p;
			ST_THR: begin
				lt_a_q <= (s10_q < a_q);
				prod_q <= mul_p;
			end
			ST_END: begin
				lt_thr_q <= !diff_neg && (s10_q < prod_q);
				prod_q   <= mul_p;
			end
			ST_DECIDE: begin
				// Only used on the ramp, where the scaled distance is below the
				// ramp length and so fits the divide word.
				wrk_q  <= s10_q[DIV_W-1:0];
				quot_q <= '0;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end
			ST_DIV: begin
				quot_q <= {quot_q[DIV_W-2:0], sub_ge};
				if (cnt_q == '0) begin
					wrk_q <= {quot_q[DIV_W-2:0], sub_ge};
					res_q <= '0;
					bit_q <= ROOT_BIT_INIT;
					cnt_q <= CNT_W'(ROOT_W - 1);
				end else begin
					wrk_q <= sub_ge ? sub_d[DIV_W-1:0] : rem2[DIV_W-1:0];
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_ROOT: begin
				if (sub_ge) begin
					wrk_q <= sub_d[DIV_W-1:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
		if (load_out) begin
			o_pulse_q <= pulse_q;
			o_color_q <= color_q;
			o_boost_q <= boost_q;
			o_clear_q <= clear_q;
			o_phase_q <= phase_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.esc_pulse_us = o_pulse_q;
	assign result.led_red      = o_color_q[COLOR_W-1:2*LED_W];
	assign result.led_green    = o_color_q[2*LED_W-1:LED_W];
	assign result.led_blue     = o_color_q[LED_W-1:0];
	assign result.boost_enable = o_boost_q;
	assign result.clear_counts = o_clear_q;
	assign result.run_phase    = o_phase_q;

endmodule

[rtl/core/drsp_chk.sv]
// Port checker for the profiler core and its bind to the top level.
`timescale 1ns / 1ps

module drsp_chk import drsp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [PULSE_W-1:0] esc_pulse_us,
	input logic [LED_W-1:0]   led_red,
	input logic               boost_enable,
	input logic               clear_counts,
	input logic [PHASE_W-1:0] run_phase
);

	// The sample port drops ready in the cycle after it takes an item.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample port ready right after an item was taken");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(esc_pulse_us) && $stable(run_phase))
		else $error("stalled result changed or vanished");

	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (esc_pulse_us >= PULSE_STOP) && (esc_pulse_us <= PULSE_CRUISE))
		else $error("pulse width outside the drive profile");

	a_estop_safe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (run_phase == PH_ESTOP) |->
			!boost_enable && !clear_counts && (esc_pulse_us == PULSE_NEUTRAL) &&
			(led_red == {LED_W{1'b1}}))
		else $error("emergency stop result is not safe");

	a_armed_outputs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (run_phase == PH_ARMED) |->
			boost_enable && clear_counts && (esc_pulse_us == PULSE_NEUTRAL))
		else $error("armed result lacks boost, clear or neutral pulse");

endmodule

bind distance_run_speed_profiler_core drsp_chk u_drsp_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample.valid),
	.in_ready     (sample.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.esc_pulse_us (result.esc_pulse_us),
	.led_red      (result.led_red),
	.boost_enable (result.boost_enable),
	.clear_counts (result.clear_counts),
	.run_phase    (result.run_phase)
);

[verif/tb.sv]
// Self-checking testbench for the distance run speed profiler core.
`timescale 1ns / 1ps

module tb;
	import drsp_pkg::*;

	// One encoder and button sample as it travels on the sample channel.
	typedef struct packed {
		logic signed [IN_W-1:0] left_cnt;
		logic signed [IN_W-1:0] right_cnt;
		logic                   go;
		logic                   stop;
	} enc_sample_t;

	// One drive command as it travels on the result channel.
	typedef struct packed {
		logic [PULSE_W-1:0] pulse;
		logic [LED_W-1:0]   red;
		logic [LED_W-1:0]   green;
		logic [LED_W-1:0]   blue;
		logic               boost;
		logic               clear;
		logic [PHASE_W-1:0] phase;
	} drive_cmd_t;

	// A row of the directed table; the command counts only where typed is set.
	typedef struct packed {
		enc_sample_t smp;
		logic        typed;
		drive_cmd_t  cmd;
	} dir_row_t;

	// Register byte offsets on the configuration port.
	localparam logic [ADDR_W-1:0] ADDR_TICKS = 4'h0;
	localparam logic [ADDR_W-1:0] ADDR_RUN   = 4'h4;
	localparam logic [ADDR_W-1:0] ADDR_ACCEL = 4'h8;
	localparam logic [ADDR_W-1:0] ADDR_DECEL = 4'hC;

	// With no handshake at all for this many cycles, the block can only be hung.
	localparam int HANG_LIMIT   = 20000;
	localparam int NUM_PHASES   = 9;
	localparam int PHASE_ITEMS  = 115;
	localparam int NUM_DIR_ROWS = 24;
	localparam int SPAN_MAX     = 16777214;

	localparam int MAX_POS = 8388607;
	localparam int MAX_NEG = -8388608;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	drsp_in_if  sample_ch ();
	drsp_out_if cmd_ch ();

	distance_run_speed_profiler_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (cmd_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the profile registers and of the run state, as the block holds them.
	drsp_cfg_t          prof_cfg;
	logic [PHASE_W-1:0] run_ph      = PH_IDLE;
	logic [PULSE_W-1:0] hold_pulse  = PULSE_NEUTRAL;
	logic [COLOR_W-1:0] hold_color  = '0;
	logic               hold_boost  = 1'b0;

	drive_cmd_t pending_cmds [$];
	int         mismatches  = 0;
	int         items_sent  = 0;
	int         src_idle_pct  = 0;
	int         sink_stall_pct = 0;
	int         quiet_cycles  = 0;
	dir_row_t   dir_rows [NUM_DIR_ROWS];

	// Distance from one signed count; the most negative count has the largest
	// magnitude of all.
	function automatic longint unsigned count_mag(logic [IN_W-1:0] raw);
		if (raw[IN_W-1])
			return (longint'(1) << IN_W) - longint'(raw);
		return longint'(raw);
	endfunction

	// Integer square root, built one bit at a time from the top.
	function automatic logic [ROOT_W-1:0] floor_root(logic [DIV_W-1:0] v);
		logic [ROOT_W-1:0] root;
		logic [ROOT_W-1:0] cand;
		root = '0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			cand = root | (ROOT_W'(1) << b);
			if (longint'(cand) * longint'(cand) <= longint'(v))
				root = cand;
		end
		return root;
	endfunction

	// Places the run by distance, starting from the given phase. A single sample
	// may drop through ramp, cruise and slow zone and land on the end of the run.
	function automatic void judge_run(longint unsigned travel, logic [PHASE_W-1:0] from_ph);
		longint unsigned tk;
		longint unsigned s10;
		longint unsigned ramp;
		longint unsigned frac;
		longint unsigned lvl;
		longint          thr;
		logic [ROOT_W-1:0] root;
		logic [PHASE_W-1:0] ph;
		tk  = prof_cfg.ticks_per_meter_tenths;
		s10 = travel * SCALE_MM;
		ph  = from_ph;
		if (ph == PH_ACCEL) begin
			ramp = longint'(prof_cfg.accel_distance_mm) * tk;
			if (s10 < ramp) begin
				frac       = (s10 << 32) / ramp;
				root       = floor_root(frac[DIV_W-1:0]);
				lvl        = (LAMP_MAX * longint'(root)) >> 16;
				run_ph     = PH_ACCEL;
				hold_pulse = PULSE_SLOW + PULSE_W'((RAMP_SPAN * longint'(root) + 32768) >> 16);
				hold_color = {lvl[LED_W-1:0], lvl[LED_W-1:0], LED_W'(0)};
				return;
			end
			ph = PH_CRUISE;
		end
		if (ph == PH_CRUISE) begin
			// The slow zone may be longer than the run, which makes this negative.
			thr = (longint'(prof_cfg.run_distance_mm) - longint'(prof_cfg.decel_distance_mm))
				* longint'(tk);
			if (longint'(s10) < thr) begin
				run_ph     = PH_CRUISE;
				hold_pulse = PULSE_CRUISE;
				hold_color = COLOR_YELLOW;
				return;
			end
		end
		if (s10 < longint'(prof_cfg.run_distance_mm) * tk) begin
			run_ph     = PH_DECEL;
			hold_pulse = PULSE_SLOW;
			hold_color = COLOR_BLUE;
			return;
		end
		// End of the run: the boost converter is left as it was.
		run_ph     = PH_IDLE;
		hold_pulse = PULSE_STOP;
		hold_color = COLOR_RED;
	endfunction

	// Advances the shadow state by one sample and returns the command it gives.
	function automatic drive_cmd_t step_profile(enc_sample_t smp);
		longint unsigned travel;
		logic            clr;
		drive_cmd_t      cmd;
		travel = count_mag(smp.left_cnt) + count_mag(smp.right_cnt);
		if (travel > (longint'(1) << COUNT_BITS) - 1)
			travel = (longint'(1) << COUNT_BITS) - 1;
		clr = 1'b0;
		if (smp.stop) begin
			// The emergency stop wins over everything, in every phase.
			run_ph     = PH_ESTOP;
			hold_pulse = PULSE_NEUTRAL;
			hold_color = COLOR_RED;
			hold_boost = 1'b0;
		end else begin
			case (run_ph) inside
				PH_IDLE, PH_ARMED: begin
					if (smp.go) begin
						run_ph     = PH_ARMED;
						hold_boost = 1'b1;
						hold_pulse = PULSE_NEUTRAL;
						hold_color = COLOR_GREEN;
						clr        = 1'b1;
					end else if (run_ph == PH_ARMED) begin
						// Release of go: the counters are being cleared, so the
						// distance counts as zero whatever the sample says.
						clr = 1'b1;
						judge_run(64'd0, PH_ACCEL);
					end
				end
				PH_ACCEL, PH_CRUISE, PH_DECEL: begin
					judge_run(travel, run_ph);
				end
				default: begin
					run_ph = PH_IDLE;
				end
			endcase
		end
		cmd.pulse = hold_pulse;
		{cmd.red, cmd.green, cmd.blue} = hold_color;
		cmd.boost = hold_boost;
		cmd.clear = clr;
		cmd.phase = run_ph;
		return cmd;
	endfunction

	function automatic dir_row_t dir(int lc, int rc, int go, int stop, int typed,
		logic [PULSE_W-1:0] pulse, logic [COLOR_W-1:0] color, int boost, int clear,
		logic [PHASE_W-1:0] phase);
		dir_row_t row;
		row.smp.left_cnt  = IN_W'(lc);
		row.smp.right_cnt = IN_W'(rc);
		row.smp.go        = 1'(go);
		row.smp.stop      = 1'(stop);
		row.typed         = 1'(typed);
		row.cmd.pulse     = pulse;
		{row.cmd.red, row.cmd.green, row.cmd.blue} = color;
		row.cmd.boost     = 1'(boost);
		row.cmd.clear     = 1'(clear);
		row.cmd.phase     = phase;
		return row;
	endfunction

	// Any sample at all: counts over their whole range, buttons at random.
	function automatic enc_sample_t rand_sample();
		enc_sample_t smp;
		smp.left_cnt  = IN_W'($urandom);
		smp.right_cnt = IN_W'($urandom);
		smp.go        = 1'($urandom_range(0, 1));
		smp.stop      = ($urandom_range(0, 3) == 0);
		return smp;
	endfunction

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Offers one sample, with random idle cycles ahead of it, and records the
	// expected command once the block takes it.
	task automatic push_sample(enc_sample_t smp, logic typed, drive_cmd_t typed_cmd);
		drive_cmd_t predicted;
		@(negedge clk);
		while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.left_count  <= smp.left_cnt;
		sample_ch.right_count <= smp.right_cnt;
		sample_ch.go_button   <= smp.go;
		sample_ch.stop_button <= smp.stop;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		predicted = step_profile(smp);
		pending_cmds.push_back(typed ? typed_cmd : predicted);
		items_sent++;
	endtask

	// Holds back the sender until every command already owed has come out.
	task automatic drain();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_access(logic wr, logic [ADDR_W-1:0] addr, logic [APB_DW-1:0] wdata,
		output logic [APB_DW-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes one register and reads it back.
	task automatic set_reg(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] value);
		logic [APB_DW-1:0] rdata;
		apb_access(1'b1, addr, APB_DW'(value), rdata);
		apb_access(1'b0, addr, '0, rdata);
		if (rdata[CFG_W-1:0] !== value) begin
			mismatches++;
			$display("%0t ns: register at 0x%0h reads back wrong, expected %0d, got %0d",
				$time, addr, value, rdata[CFG_W-1:0]);
		end
	endtask

	task automatic load_profile(drsp_cfg_t c);
		set_reg(ADDR_TICKS, c.ticks_per_meter_tenths);
		set_reg(ADDR_RUN, c.run_distance_mm);
		set_reg(ADDR_ACCEL, c.accel_distance_mm);
		set_reg(ADDR_DECEL, c.decel_distance_mm);
		prof_cfg = c;
	endtask

	// One well-formed run: go held, released, then counts that grow from zero
	// past the end of the run, with now and then a stray go or an emergency stop.
	task automatic run_profile();
		longint unsigned tk;
		longint unsigned end_s;
		longint unsigned span;
		longint unsigned travel;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned lm;
		longint unsigned rm;
		int              n;
		enc_sample_t     smp;
		tk    = prof_cfg.ticks_per_meter_tenths;
		end_s = (longint'(prof_cfg.run_distance_mm) * tk) / SCALE_MM + 1;
		span  = end_s + end_s / 8 + 2;
		if (span > SPAN_MAX)
			span = SPAN_MAX;
		repeat ($urandom_range(1, 3)) begin
			smp      = rand_sample();
			smp.go   = 1'b1;
			smp.stop = 1'b0;
			push_sample(smp, 1'b0, '0);
		end
		smp      = rand_sample();
		smp.go   = 1'b0;
		smp.stop = 1'b0;
		push_sample(smp, 1'b0, '0);
		n = $urandom_range(4, 30);
		for (int k = 1; k <= n; k++) begin
			travel = span * k / n + $urandom_range(0, 32'(span / (2 * n)));
			if (travel > SPAN_MAX)
				travel = SPAN_MAX;
			// Split the distance over both wheels, each within a positive count.
			lo = (travel > MAX_POS) ? travel - MAX_POS : 0;
			hi = (travel < MAX_POS) ? travel : MAX_POS;
			lm = $urandom_range(32'(lo), 32'(hi));
			rm = travel - lm;
			smp.left_cnt  = $urandom_range(0, 1) ? IN_W'(-longint'(lm)) : IN_W'(lm);
			smp.right_cnt = $urandom_range(0, 1) ? IN_W'(-longint'(rm)) : IN_W'(rm);
			smp.go        = ($urandom_range(0, 9) == 0);
			smp.stop      = ($urandom_range(0, 39) == 0);
			push_sample(smp, 1'b0, '0);
			if (smp.stop)
				break;
		end
	endtask

	// Random receiver stalls, at the rate of the current phase.
	always @(negedge clk) begin
		cmd_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Every command that comes out is held against the oldest one owed.
	always @(posedge clk) begin
		drive_cmd_t want;
		if (cmd_ch.valid && cmd_ch.ready) begin
			if (pending_cmds.size() == 0) begin
				mismatches++;
				$display("%0t ns: command with none expected, pulse %0d phase %0d",
					$time, cmd_ch.esc_pulse_us, cmd_ch.run_phase);
			end else begin
				want = pending_cmds.pop_front();
				check_field("esc_pulse_us", want.pulse, cmd_ch.esc_pulse_us);
				check_field("led_red", want.red, cmd_ch.led_red);
				check_field("led_green", want.green, cmd_ch.led_green);
				check_field("led_blue", want.blue, cmd_ch.led_blue);
				check_field("boost_enable", want.boost, cmd_ch.boost_enable);
				check_field("clear_counts", want.clear, cmd_ch.clear_counts);
				check_field("run_phase", want.phase, cmd_ch.run_phase);
			end
		end
	end

	// Hang detection: counts cycles in which no handshake of any kind completes.
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (cmd_ch.valid && cmd_ch.ready)
			|| (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= HANG_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles", $time, HANG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		drsp_cfg_t  cfg;
		enc_sample_t smp;
		int         start;
		bit         paused;

		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		sample_ch.valid       = 1'b0;
		sample_ch.left_count  = '0;
		sample_ch.right_count = '0;
		sample_ch.go_button   = 1'b0;
		sample_ch.stop_button = 1'b0;
		prof_cfg.ticks_per_meter_tenths = 16'd1461;
		prof_cfg.run_distance_mm        = 16'd8500;
		prof_cfg.accel_distance_mm      = 16'd500;
		prof_cfg.decel_distance_mm      = 16'd1500;

		// Directed walk under the reset profile. With 146.1 ticks per meter the
		// ramp ends at 73 ticks, cruise at 1023 ticks and the run at 1242 ticks.
		// Typed rows can be read off directly: idle, arming, release of go (judged at zero
		// distance whatever the counts say), cruise, slow zone, end of run, emergency stop.
		dir_rows[0]  = dir(0, 0, 0, 0, 1, PULSE_NEUTRAL, '0, 0, 0, PH_IDLE);
		dir_rows[1]  = dir(0, 0, 1, 0, 1, PULSE_NEUTRAL, COLOR_GREEN, 1, 1, PH_ARMED);
		dir_rows[2]  = dir(MAX_POS, MAX_NEG, 1, 0, 1, PULSE_NEUTRAL, COLOR_GREEN, 1, 1,
			PH_ARMED);
		dir_rows[3]  = dir(MAX_NEG, MAX_NEG, 0, 0, 1, PULSE_SLOW, '0, 1, 1, PH_ACCEL);
		dir_rows[4]  = dir(20, -20, 0, 0, 0, '0, '0, 0, 0, PH_IDLE);
		// A go press in a running phase changes nothing.
		dir_rows[5]  = dir(30, 30, 1, 0, 0, '0, '0, 0, 0, PH_IDLE);
		// Just short of the end of the ramp.
		dir_rows[6]  = dir(50, -23, 0, 0, 0, '0, '0, 0, 0, PH_IDLE);
		// From the ramp straight through cruise and slow zone to the end.
		dir_rows[7]  = dir(700, -700, 0, 0, 1, PULSE_STOP, COLOR_RED, 1, 0, PH_IDLE);
		dir_rows[8]  = dir(5, 5, 0, 0, 1, PULSE_STOP, COLOR_RED, 1, 0, PH_IDLE);
		dir_rows[9]  = dir(0, 0, 0, 1, 1, PULSE_NEUTRAL, COLOR_RED, 0, 0, PH_ESTOP);
		dir_rows[10] = dir(0, 0, 1, 1, 1, PULSE_NEUTRAL, COLOR_RED, 0, 0, PH_ESTOP);
		// Leaving the stop goes to idle even with go held.
		dir_rows[11] = dir(0, 0, 1, 0, 1, PULSE_NEUTRAL, COLOR_RED, 0, 0, PH_IDLE);
		dir_rows[12] = dir(0, 0, 1, 0, 1, PULSE_NEUTRAL, COLOR_GREEN, 1, 1, PH_ARMED);
		dir_rows[13] = dir(-1, 1, 0, 0, 1, PULSE_SLOW, '0, 1, 1, PH_ACCEL);
		dir_rows[14] = dir(100, 0, 0, 0, 1, PULSE_CRUISE, COLOR_YELLOW, 1, 0, PH_CRUISE);
		dir_rows[15] = dir(-600, 500, 0, 0, 1, PULSE_SLOW, COLOR_BLUE, 1, 0, PH_DECEL);
		dir_rows[16] = dir(-600, 500, 0, 1, 1, PULSE_NEUTRAL, COLOR_RED, 0, 0, PH_ESTOP);
		dir_rows[17] = dir(0, 0, 0, 0, 1, PULSE_NEUTRAL, COLOR_RED, 0, 0, PH_IDLE);
		dir_rows[18] = dir(0, 0, 1, 0, 1, PULSE_NEUTRAL, COLOR_GREEN, 1, 1, PH_ARMED);
		dir_rows[19] = dir(0, 0, 0, 0, 1, PULSE_SLOW, '0, 1, 1, PH_ACCEL);
		// Both counts at their most negative: the sum saturates, the run ends.
		dir_rows[20] = dir(MAX_NEG, MAX_NEG, 0, 0, 1, PULSE_STOP, COLOR_RED, 1, 0, PH_IDLE);
		dir_rows[21] = dir(MAX_POS, MAX_POS, 1, 0, 1, PULSE_NEUTRAL, COLOR_GREEN, 1, 1,
			PH_ARMED);
		dir_rows[22] = dir(MAX_POS, 0, 0, 1, 1, PULSE_NEUTRAL, COLOR_RED, 0, 0, PH_ESTOP);
		dir_rows[23] = dir(0, 0, 0, 0, 1, PULSE_NEUTRAL, COLOR_RED, 0, 0, PH_IDLE);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				// Registers change only with the block idle and nothing owed.
				drain();
				repeat (8) @(posedge clk);
				case (ph)
					1: cfg = '{16'd1461, 16'd8500, 16'd500, 16'd1500};
					// Zero everywhere: no ramp and every running sample ends the run.
					2: cfg = '{16'd0, 16'd0, 16'd0, 16'd0};
					3: cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
					// Slow zone longer than the run, so cruise never happens.
					4: cfg = '{16'd1461, 16'd1000, 16'd200, 16'hFFFF};
					// No ramp at all.
					5: cfg = '{16'd1461, 16'd4000, 16'd0, 16'd1000};
					6: cfg = '{16'hFFFF, 16'd300, 16'd100, 16'd50};
					7: cfg = '{CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
						CFG_W'($urandom)};
					default: cfg = '{CFG_W'($urandom_range(500, 20000)),
						CFG_W'($urandom_range(100, 10000)), CFG_W'($urandom_range(0, 2000)),
						CFG_W'($urandom_range(0, 4000))};
				endcase
				load_profile(cfg);
			end

			case (ph % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
				default: begin src_idle_pct = 36; sink_stall_pct = 36; end
			endcase

			if (ph == 0) begin
				for (int i = 0; i < NUM_DIR_ROWS; i++)
					push_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].cmd);
			end

			start  = items_sent;
			paused = 1'b0;
			while (items_sent - start < PHASE_ITEMS) begin
				// Halfway through, let the block run dry before going on.
				if (!paused && items_sent - start >= PHASE_ITEMS / 2) begin
					drain();
					paused = 1'b1;
				end
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 4)) begin
						smp = rand_sample();
						push_sample(smp, 1'b0, '0);
					end
				end else begin
					run_profile();
				end
			end
		end

		drain();
		// Keep the clock running so that a stray extra command would still be seen.
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
